FILE: rtl/mlfr_pkg.sv
// Package with the types and codes shared by the marker/length frame receiver.
package mlfr_pkg;

   typedef enum logic [2:0] {
      PH_HUNT   = 3'd0,
      PH_START2 = 3'd1,
      PH_ERR    = 3'd2,
      PH_LEN    = 3'd3,
      PH_DATA   = 3'd4,
      PH_END    = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      ST_PAYLOAD    = 3'd0,
      ST_OK         = 3'd1,
      ST_BAD_START1 = 3'd2,
      ST_BAD_START2 = 3'd3,
      ST_BAD_END    = 3'd4,
      ST_TIMEOUT    = 3'd5
   } status_type;

   localparam int unsigned CSR_ADDR_WIDTH = 4;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   localparam logic [1:0] REG_FIRST_START  = 2'd0;
   localparam logic [1:0] REG_SECOND_START = 2'd1;
   localparam logic [1:0] REG_END_MARKER   = 2'd2;

endpackage

FILE: rtl/marker_length_frame_receiver.sv
// Top level of the marker/length frame receiver.
//
// The block takes one received byte or one timeout tick per item and hunts for
// frames made of two start markers, a device error byte, a length byte, that
// many payload bytes and an end marker. Each payload byte leaves as a result
// item together with the header error byte and length; the end marker gives a
// frame-ok or bad-end item, and a wrong marker or a timeout gives an error item
// and a return to hunting. Markers and header bytes give no result item. An
// item passes an input register and then the frame state logic, which loads
// the result register, so the block takes one item per cycle unless a stalled
// result holds it. The user sets the three marker values through the register
// port while the block is idle; the block itself does not enforce this.
module marker_length_frame_receiver (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [7:0]                             req_rx_byte,
   input  logic                                   req_timed_out,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [2:0]                             rsp_status,
   output logic [7:0]                             rsp_device_error,
   output logic [7:0]                             rsp_frame_length,
   output logic [7:0]                             rsp_payload_byte,
   output logic                                   rsp_last_payload,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [mlfr_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [mlfr_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [mlfr_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                   csr_pready
);
   import mlfr_pkg::*;

   logic [7:0]  first_start_ff;
   logic [7:0]  second_start_ff;
   logic [7:0]  end_marker_ff;
   logic        csr_write;
   logic [1:0]  csr_index;

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_timed_out_ff;

   phase_type   phase_ff;
   phase_type   phase_in;
   logic [7:0]  bytes_left_ff;
   logic [7:0]  bytes_left_in;
   logic [7:0]  held_error_ff;
   logic [7:0]  held_error_in;
   logic [7:0]  held_length_ff;
   logic [7:0]  held_length_in;

   logic        out_valid_ff;
   status_type  out_status_ff;
   logic [7:0]  out_error_ff;
   logic [7:0]  out_length_ff;
   logic [7:0]  out_payload_ff;
   logic        out_last_ff;

   logic        out_free;
   logic        process;
   logic        res_valid;
   status_type  res_status;
   logic        res_header;
   logic [7:0]  res_payload;
   logic        res_last;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_start_ff  <= 8'd0;
         second_start_ff <= 8'd0;
         end_marker_ff   <= 8'd0;
      end else if (csr_write) begin
         case (csr_index)
            REG_FIRST_START:  first_start_ff  <= csr_pwdata[7:0];
            REG_SECOND_START: second_start_ff <= csr_pwdata[7:0];
            REG_END_MARKER:   end_marker_ff   <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_FIRST_START:  csr_prdata = {24'd0, first_start_ff};
         REG_SECOND_START: csr_prdata = {24'd0, second_start_ff};
         REG_END_MARKER:   csr_prdata = {24'd0, end_marker_ff};
         default:          csr_prdata = '0;
      endcase
   end

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign process   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (process) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff      <= req_rx_byte;
         in_timed_out_ff <= req_timed_out;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      if (in_timed_out_ff) begin
         phase_in = PH_HUNT;
      end else begin
         case (phase_ff)
            PH_START2: begin
               phase_in = (in_byte_ff == second_start_ff) ? PH_ERR : PH_HUNT;
            end
            PH_ERR: begin
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               phase_in = (in_byte_ff == 8'd0) ? PH_END : PH_DATA;
            end
            PH_DATA: begin
               phase_in = (bytes_left_ff <= 8'd1) ? PH_END : PH_DATA;
            end
            PH_END: begin
               phase_in = PH_HUNT;
            end
            default: begin
               phase_in = (in_byte_ff == first_start_ff) ? PH_START2 : PH_HUNT;
            end
         endcase
      end
   end

   always_comb begin
      bytes_left_in  = bytes_left_ff;
      held_error_in  = held_error_ff;
      held_length_in = held_length_ff;
      res_valid      = 1'b0;
      res_status     = ST_PAYLOAD;
      res_header     = 1'b0;
      res_payload    = 8'd0;
      res_last       = 1'b0;
      if (in_timed_out_ff) begin
         res_valid  = 1'b1;
         res_status = ST_TIMEOUT;
         res_header = (phase_ff == PH_DATA) || (phase_ff == PH_END);
      end else begin
         case (phase_ff)
            PH_START2: begin
               if (in_byte_ff != second_start_ff) begin
                  res_valid  = 1'b1;
                  res_status = ST_BAD_START2;
               end
            end
            PH_ERR: begin
               held_error_in = in_byte_ff;
            end
            PH_LEN: begin
               held_length_in = in_byte_ff;
               bytes_left_in  = in_byte_ff;
            end
            PH_DATA: begin
               res_valid   = 1'b1;
               res_status  = ST_PAYLOAD;
               res_header  = 1'b1;
               res_payload = in_byte_ff;
               res_last    = (bytes_left_ff <= 8'd1);
               bytes_left_in = res_last ? 8'd0 : bytes_left_ff - 8'd1;
            end
            PH_END: begin
               res_valid  = 1'b1;
               res_status = (in_byte_ff == end_marker_ff) ? ST_OK : ST_BAD_END;
               res_header = 1'b1;
            end
            default: begin
               if (in_byte_ff != first_start_ff) begin
                  res_valid  = 1'b1;
                  res_status = ST_BAD_START1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         bytes_left_ff  <= 8'd0;
         held_error_ff  <= 8'd0;
         held_length_ff <= 8'd0;
      end else if (process) begin
         phase_ff       <= phase_in;
         bytes_left_ff  <= bytes_left_in;
         held_error_ff  <= held_error_in;
         held_length_ff <= held_length_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= process && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (process && res_valid) begin
         out_status_ff  <= res_status;
         out_error_ff   <= res_header ? held_error_ff : 8'd0;
         out_length_ff  <= res_header ? held_length_ff : 8'd0;
         out_payload_ff <= res_payload;
         out_last_ff    <= res_last;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_device_error = out_error_ff;
   assign rsp_frame_length = out_length_ff;
   assign rsp_payload_byte = out_payload_ff;
   assign rsp_last_payload = out_last_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_status_ff != ST_PAYLOAD) |->
         (out_payload_ff == 8'd0) && !out_last_ff)
      else $error("Non-payload result carries payload data.");

   assert property (@(posedge clock) disable iff (reset)
      process && in_timed_out_ff |=> (phase_ff == PH_HUNT))
      else $error("Timeout did not return the receiver to hunting.");

   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (bytes_left_ff != 8'd0))
      else $error("Payload phase with no bytes left.");

   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("Input stalled without a blocked result.");
`endif

endmodule

FILE: test/mlfr_frame_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the frame receiver's result items and compares them with the block.
module mlfr_frame_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [7:0]                          req_rx_byte,
   input  logic                                req_timed_out,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [2:0]                          rsp_status,
   input  logic [7:0]                          rsp_device_error,
   input  logic [7:0]                          rsp_frame_length,
   input  logic [7:0]                          rsp_payload_byte,
   input  logic                                rsp_last_payload,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mlfr_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [mlfr_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   input  logic                                csr_pready,
   output int                                  mismatch_count,
   output int                                  pending_count,
   output int                                  checked_count
);
   import mlfr_pkg::*;

   localparam int unsigned PRINT_LIMIT = 20;

   typedef struct packed {
      status_type status;
      logic [7:0] device_error;
      logic [7:0] frame_length;
      logic [7:0] payload_byte;
      logic       last_payload;
   } frame_result_type;

   frame_result_type expected_results[$];
   phase_type     frame_phase;
   logic [7:0]    bytes_left;
   logic [7:0]    held_error;
   logic [7:0]    held_length;
   logic [7:0]    first_marker;
   logic [7:0]    second_marker;
   logic [7:0]    end_marker;

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("frame checker: %s got %0d expected %0d at %0t", what, got, want, $realtime);
      end
      mismatch_count++;
   endtask

   task automatic push_result(input status_type status, input logic with_header,
                              input logic [7:0] data, input logic last);
      frame_result_type res;
      res.status       = status;
      res.device_error = with_header ? held_error : 8'h00;
      res.frame_length = with_header ? held_length : 8'h00;
      res.payload_byte = data;
      res.last_payload = last;
      expected_results.push_back(res);
      pending_count++;
   endtask

   task automatic predict_frame_byte(input logic [7:0] rx, input logic timed_out);
      logic last_byte;
      if (timed_out) begin
         push_result(ST_TIMEOUT, frame_phase == PH_DATA || frame_phase == PH_END, 8'h00, 1'b0);
         frame_phase = PH_HUNT;
      end else begin
         case (frame_phase)
            PH_START2: begin
               if (rx == second_marker) begin
                  frame_phase = PH_ERR;
               end else begin
                  push_result(ST_BAD_START2, 1'b0, 8'h00, 1'b0);
                  frame_phase = PH_HUNT;
               end
            end
            PH_ERR: begin
               held_error  = rx;
               frame_phase = PH_LEN;
            end
            PH_LEN: begin
               held_length = rx;
               bytes_left  = rx;
               frame_phase = (rx == 8'h00) ? PH_END : PH_DATA;
            end
            PH_DATA: begin
               last_byte = (bytes_left <= 8'd1);
               push_result(ST_PAYLOAD, 1'b1, rx, last_byte);
               bytes_left = bytes_left - 8'd1;
               if (last_byte) begin
                  bytes_left  = 8'h00;
                  frame_phase = PH_END;
               end
            end
            PH_END: begin
               push_result((rx == end_marker) ? ST_OK : ST_BAD_END, 1'b1, 8'h00, 1'b0);
               frame_phase = PH_HUNT;
            end
            default: begin
               if (rx == first_marker) begin
                  frame_phase = PH_START2;
               end else begin
                  push_result(ST_BAD_START1, 1'b0, 8'h00, 1'b0);
                  frame_phase = PH_HUNT;
               end
            end
         endcase
      end
   endtask

   task automatic check_result();
      frame_result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("result item with none expected, status", int'(rsp_status), 0);
         return;
      end
      want = expected_results.pop_front();
      pending_count--;
      checked_count++;
      if (rsp_status != want.status) begin
         report_mismatch("status", int'(rsp_status), int'(want.status));
      end
      if (rsp_device_error != want.device_error) begin
         report_mismatch("device_error", int'(rsp_device_error), int'(want.device_error));
      end
      if (rsp_frame_length != want.frame_length) begin
         report_mismatch("frame_length", int'(rsp_frame_length), int'(want.frame_length));
      end
      if (rsp_payload_byte != want.payload_byte) begin
         report_mismatch("payload_byte", int'(rsp_payload_byte), int'(want.payload_byte));
      end
      if (rsp_last_payload != want.last_payload) begin
         report_mismatch("last_payload", int'(rsp_last_payload), int'(want.last_payload));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_results.delete();
         frame_phase    = PH_HUNT;
         bytes_left     = 8'h00;
         held_error     = 8'h00;
         held_length    = 8'h00;
         first_marker   = 8'h00;
         second_marker  = 8'h00;
         end_marker     = 8'h00;
         mismatch_count = 0;
         pending_count  = 0;
         checked_count  = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_WIDTH-1:2])
               REG_FIRST_START:  first_marker  = csr_pwdata[7:0];
               REG_SECOND_START: second_marker = csr_pwdata[7:0];
               REG_END_MARKER:   end_marker    = csr_pwdata[7:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            check_result();
         end
         if (req_valid && !req_stall) begin
            predict_frame_byte(req_rx_byte, req_timed_out);
         end
      end
   end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Top of the frame receiver testbench: clock, reset, stimulus and the final verdict.
module tb_top;
   import mlfr_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned SETTLE_CYCLES = 6;
   localparam logic [1:0]  REG_UNUSED    = 2'd3;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [7:0]                req_rx_byte = 8'h00;
   logic                      req_timed_out = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [2:0]                rsp_status;
   logic [7:0]                rsp_device_error;
   logic [7:0]                rsp_frame_length;
   logic [7:0]                rsp_payload_byte;
   logic                      rsp_last_payload;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   int         mismatch_count;
   int         pending_count;
   int         checked_count;
   int         sender_idle_pct = 0;
   int         receiver_idle_pct = 0;
   int         items_sent = 0;
   int         cycle_count = 0;
   logic [7:0] first_marker = 8'h00;
   logic [7:0] second_marker = 8'h00;
   logic [7:0] end_marker = 8'h00;

   marker_length_frame_receiver i_dut (.*);

   mlfr_frame_checker i_checker (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic write_register(input logic [1:0] index, input logic [7:0] value);
      logic [CSR_DATA_WIDTH-1:0] data;
      data        = $urandom();
      data[7:0]   = value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_markers(input logic [7:0] first, input logic [7:0] second,
                              input logic [7:0] closing);
      first_marker  = first;
      second_marker = second;
      end_marker    = closing;
      write_register(REG_FIRST_START, first);
      write_register(REG_SECOND_START, second);
      write_register(REG_END_MARKER, closing);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_item(input logic [7:0] rx, input logic timed_out);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_rx_byte   <= rx;
      req_timed_out <= timed_out;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // Mostly complete frames with random content; the rest is line noise and
   // frames cut short by a wrong byte or a timeout.
   task automatic send_random_frame();
      logic [7:0] frame_bytes[$];
      int         kind;
      int         len;
      int         cut;
      kind = $urandom_range(99);
      if (kind < 15) begin
         send_item(8'($urandom_range(255)), $urandom_range(7) == 0);
         return;
      end
      len = ($urandom_range(199) == 0) ? 255 : $urandom_range(7);
      frame_bytes.push_back(first_marker);
      frame_bytes.push_back(second_marker);
      frame_bytes.push_back(8'($urandom_range(255)));
      frame_bytes.push_back(8'(len));
      repeat (len) frame_bytes.push_back(8'($urandom_range(255)));
      frame_bytes.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : end_marker);
      if (kind < 30) begin
         cut = $urandom_range(frame_bytes.size() - 1);
         while (frame_bytes.size() > cut + 1) void'(frame_bytes.pop_back());
         frame_bytes[cut] = 8'($urandom_range(255));
      end
      foreach (frame_bytes[i]) begin
         if ($urandom_range(49) == 0) begin
            send_item(8'($urandom_range(255)), 1'b1);
            return;
         end
         send_item(frame_bytes[i], 1'b0);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      sender_idle_pct   = 33;
      receiver_idle_pct = 72;
      set_markers(8'hA5, 8'h5A, 8'h7E);
      send_item(8'h3C, 1'b1);
      send_item(8'hFF, 1'b0);
      send_item(first_marker, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(first_marker, 1'b0);
      send_item(second_marker, 1'b0);
      send_item(8'hFF, 1'b1);
      send_item(first_marker, 1'b0);
      send_item(second_marker, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(end_marker, 1'b0);
      send_item(first_marker, 1'b0);
      send_item(second_marker, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'h02, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'h7F, 1'b0);
      send_item(first_marker, 1'b0);
      send_item(second_marker, 1'b0);
      send_item(8'h80, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h55, 1'b0);
      send_item(8'hAA, 1'b1);
      send_item(first_marker, 1'b0);
      send_item(second_marker, 1'b0);
      send_item(8'h01, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'h00, 1'b1);
      wait_idle();

      write_register(REG_UNUSED, 8'hFF);
      set_markers(8'h00, 8'h00, 8'h00);
      while (items_sent < 430) send_random_frame();
      wait_idle();

      sender_idle_pct   = 72;
      receiver_idle_pct = 33;
      set_markers(8'hFF, 8'hFF, 8'hFF);
      while (items_sent < 830) send_random_frame();
      wait_idle();

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      set_markers(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
      while (items_sent < 1230) send_random_frame();
      wait_idle();

      $display("Summary: %0d input items sent, %0d result items checked.",
               items_sent, checked_count);
      $display("Summary: directed header cases, then framed traffic under three marker settings.");
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
